### hdl/miller_rabin_primality_test_defines.svh
// assertion macros for the primality test block
// used by the port checker, expects clk and arst_n in scope
`ifndef MILLER_RABIN_PRIMALITY_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIMALITY_TEST_DEFINES_SVH

// same-cycle implication
`define MRPT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrpt check failed");

// next-cycle implication
`define MRPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mrpt check failed");

`endif

### hdl/mrpt_pkg.sv
// shared types, constants and the prime table generator for the primality test
// no dependencies
package mrpt_pkg;

	localparam int WORD_W          = 64;
	localparam int WORD_LSB        = 6;
	localparam int WORDS_DEF       = 16;
	localparam int PRIME_DEPTH_DEF = 1000;
	localparam int MAX_PRIMES      = 1000;
	localparam int MAX_ROUNDS      = 1000;
	localparam int ROUNDS_W        = 10;
	localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 10'd20;
	localparam int SIEVE_LIMIT     = 7920;
	localparam int PRIME_W         = 16;
	localparam int OUT_DATA_W      = 8;

	typedef logic [PRIME_W-1:0] prime_tab_t [MAX_PRIMES];

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_MINUS,
		ST_CHECK,
		ST_SHIFT,
		ST_BASE,
		ST_ROM,
		ST_REDUCE,
		ST_EXP,
		ST_MSTEP,
		ST_ADD,
		ST_FIX,
		ST_MEND,
		ST_TEST,
		ST_SQR,
		ST_SQCHK,
		ST_DONE
	} mrpt_state_t;

	typedef enum logic [1:0] {
		PH_R,
		PH_B,
		PH_SQ
	} mrpt_phase_t;

	// sieve over the first primes, marking multiples by repeated addition
	function automatic prime_tab_t gen_primes();
		logic [SIEVE_LIMIT-1:0] comp;
		prime_tab_t tab;
		int cnt;
		comp = '0;
		cnt = 0;
		for (int i = 0; i < MAX_PRIMES; i++) begin
			tab[i] = '0;
		end
		for (int c = 2; c < SIEVE_LIMIT; c++) begin
			if (!comp[c]) begin
				if (cnt < MAX_PRIMES) begin
					tab[cnt] = PRIME_W'(c);
				end
				cnt++;
				for (int k = c * c; k < SIEVE_LIMIT; k += c) begin
					comp[k] = 1'b1;
				end
			end
		end
		return tab;
	endfunction

endpackage

### hdl/miller_rabin_primality_test.sv
// miller-rabin probable prime test on a multi-word candidate, word-serial datapath
// depends on mrpt_pkg
//
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata = candidate word, tlast = last word
// m_axis    out  tvalid/tready         tdata[0] = probable prime, tuser = bad candidate
// cfg       in   cfg_we                cfg_wdata = rounds
//
// one candidate at a time; arithmetic runs one 64-bit word per cycle over the used length L
// a modular add is an add pass over L words plus a fix pass, a multiply up to 2*64*L adds
// each base costs up to 2*64*L multiplies plus up to s-1 squarings
// reset clears control; stores need no clearing, the first word of a candidate clears n
// input is taken again once the result sits in the output register
module miller_rabin_primality_test #(
	parameter int WORDS             = mrpt_pkg::WORDS_DEF,
	parameter int PRIME_TABLE_DEPTH = mrpt_pkg::PRIME_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [mrpt_pkg::WORD_W-1:0]       s_axis_tdata,  // candidate_word
	input  logic                              s_axis_tlast,  // last_word
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [mrpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // probable_prime, zero pad
	output logic                              m_axis_tuser,  // bad_candidate
	input  logic                              cfg_we,
	input  logic [mrpt_pkg::ROUNDS_W-1:0]     cfg_wdata
);
	import mrpt_pkg::*;

	localparam int VW    = WORDS * WORD_W;
	localparam int WI_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LEN_W = $clog2(WORDS + 1);
	localparam int S_W   = $clog2(VW);
	localparam int PT_W  = (PRIME_TABLE_DEPTH > 1) ? $clog2(PRIME_TABLE_DEPTH) : 1;
	localparam logic [ROUNDS_W-1:0] DEPTH_CAP = ROUNDS_W'(PRIME_TABLE_DEPTH);
	localparam logic [ROUNDS_W-1:0] ROUNDS_CAP = ROUNDS_W'(MAX_ROUNDS);
	localparam prime_tab_t PRIME_ROM = gen_primes();
	localparam logic [VW-1:0] ONE_V = VW'(1);

	mrpt_state_t state_q, state_d;
	mrpt_phase_t phase_q;

	logic [VW-1:0] nv_q, mv_q, dv_q, ev_q, rv_q, bv_q, xw_q, yv_q, acc_q, tmp_q;
	logic [LEN_W-1:0] len_q, ld_idx_q;
	logic [WI_W-1:0] wi_q;
	logic carry_q, borrow_q, sel_q, dst_acc_q;
	logic [S_W-1:0] s_q, sq_q;
	logic [ROUNDS_W-1:0] h_q, rounds_q, cap;
	logic [PRIME_W-1:0] prime_q;
	logic res_prime_q, res_bad_q, out_valid_q, out_prime_q, out_bad_q;

	logic s_acc;
	logic [WORD_W-1:0] dst_word, xw_word, n_word, tmp_word, sum_lo;
	logic [WORD_W:0] sum_w, diff_w, mdiff_w;
	logic wi_last_len, wi_last_all;
	logic nv_zero, mv_zero, ev_zero, yv_zero, r_one, r_m1, lo_ge;

	assign s_acc         = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = (state_q == ST_LOAD);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_prime_q};
	assign m_axis_tuser  = out_bad_q;

	always_comb begin
		if (rounds_q > ROUNDS_CAP) begin
			cap = ROUNDS_CAP;
		end else begin
			cap = rounds_q;
		end
		if (cap > DEPTH_CAP) begin
			cap = DEPTH_CAP;
		end
	end

	// word lane of the shared add/subtract unit
	assign dst_word = dst_acc_q ? acc_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W]
		: xw_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W];
	assign xw_word  = xw_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W];
	assign n_word   = nv_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W];
	assign tmp_word = tmp_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W];
	assign sum_w    = {1'b0, dst_word} + {1'b0, xw_word} + {{WORD_W{1'b0}}, carry_q};
	assign sum_lo   = sum_w[WORD_W-1:0];
	assign diff_w   = {1'b0, sum_lo} - {1'b0, n_word} - {{WORD_W{1'b0}}, borrow_q};
	assign mdiff_w  = {1'b0, n_word} - {{WORD_W{1'b0}}, borrow_q};

	assign wi_last_len = (LEN_W'(wi_q) == len_q - LEN_W'(1));
	assign wi_last_all = (wi_q == WI_W'(WORDS - 1));
	assign nv_zero = ~|nv_q;
	assign mv_zero = ~|mv_q;
	assign ev_zero = ~|ev_q;
	assign yv_zero = ~|yv_q;
	assign r_one   = (rv_q == ONE_V);
	assign r_m1    = (rv_q == mv_q);
	assign lo_ge   = (bv_q[WORD_W-1:0] >= nv_q[WORD_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (s_acc && s_axis_tlast) state_d = ST_MINUS;
			end
			ST_MINUS: begin
				if (wi_last_all) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (mv_zero || nv_zero) ? ST_DONE : ST_SHIFT;
			end
			ST_SHIFT: begin
				if (ev_q[0]) state_d = ST_BASE;
			end
			ST_BASE: begin
				state_d = (h_q >= cap) ? ST_DONE : ST_ROM;
			end
			ST_ROM: begin
				state_d = (len_q == LEN_W'(1)) ? ST_REDUCE : ST_EXP;
			end
			ST_REDUCE: begin
				if (!lo_ge) state_d = ST_EXP;
			end
			ST_EXP: begin
				state_d = ev_zero ? ST_TEST : ST_MSTEP;
			end
			ST_MSTEP: begin
				state_d = yv_zero ? ST_MEND : ST_ADD;
			end
			ST_ADD: begin
				if (wi_last_len) state_d = ST_FIX;
			end
			ST_FIX: begin
				if (!sel_q || wi_last_len) state_d = ST_MSTEP;
			end
			ST_MEND: begin
				state_d = (phase_q == PH_SQ) ? ST_SQCHK : ST_EXP;
			end
			ST_TEST: begin
				state_d = (r_one || r_m1) ? ST_BASE : ST_SQR;
			end
			ST_SQR: begin
				state_d = (sq_q >= s_q) ? ST_DONE : ST_MSTEP;
			end
			ST_SQCHK: begin
				if (r_m1) begin
					state_d = ST_BASE;
				end else if (r_one) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SQR;
				end
			end
			ST_DONE: begin
				if (!out_valid_q) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_idx_q    <= '0;
			len_q       <= LEN_W'(1);
			rounds_q    <= ROUNDS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) rounds_q <= cfg_wdata;
			if (s_acc) begin
				if (s_axis_tlast) begin
					ld_idx_q <= '0;
				end else if (ld_idx_q < LEN_W'(WORDS)) begin
					ld_idx_q <= ld_idx_q + LEN_W'(1);
				end
				if (ld_idx_q == '0) begin
					len_q <= LEN_W'(1);
				end else if (ld_idx_q < LEN_W'(WORDS) && s_axis_tdata != '0) begin
					len_q <= ld_idx_q + LEN_W'(1);
				end
			end
			if (state_q == ST_DONE && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (s_acc) begin
					if (ld_idx_q == '0) begin
						nv_q <= VW'(s_axis_tdata);
					end else if (ld_idx_q < LEN_W'(WORDS)) begin
						nv_q[{ld_idx_q[WI_W-1:0], {WORD_LSB{1'b0}}} +: WORD_W] <= s_axis_tdata;
					end
					wi_q     <= '0;
					borrow_q <= 1'b1;
				end
			end
			ST_MINUS: begin
				mv_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W] <= mdiff_w[WORD_W-1:0];
				borrow_q <= mdiff_w[WORD_W];
				wi_q     <= wi_last_all ? '0 : wi_q + WI_W'(1);
			end
			ST_CHECK: begin
				res_prime_q <= 1'b0;
				res_bad_q   <= mv_zero;
				ev_q        <= mv_q;
				s_q         <= '0;
			end
			ST_SHIFT: begin
				if (ev_q[0]) begin
					dv_q <= ev_q;
					h_q  <= '0;
				end else begin
					ev_q <= ev_q >> 1;
					s_q  <= s_q + S_W'(1);
				end
			end
			ST_BASE: begin
				prime_q <= PRIME_ROM[h_q[PT_W-1:0]];
				if (h_q >= cap) begin
					res_prime_q <= 1'b1;
					res_bad_q   <= 1'b0;
				end
			end
			ST_ROM: begin
				bv_q <= VW'(prime_q);
				rv_q <= ONE_V;
				ev_q <= dv_q;
				h_q  <= h_q + ROUNDS_W'(1);
			end
			ST_REDUCE: begin
				// single-word n below the base: bring the base under n
				if (lo_ge) bv_q[WORD_W-1:0] <= bv_q[WORD_W-1:0] - nv_q[WORD_W-1:0];
			end
			ST_EXP: begin
				acc_q <= '0;
				if (ev_q[0]) begin
					phase_q <= PH_R;
					xw_q    <= rv_q;
					yv_q    <= bv_q;
				end else begin
					phase_q <= PH_B;
					xw_q    <= bv_q;
					yv_q    <= bv_q;
				end
			end
			ST_MSTEP: begin
				dst_acc_q <= yv_q[0];
				wi_q      <= '0;
				carry_q   <= 1'b0;
				borrow_q  <= 1'b0;
			end
			ST_ADD: begin
				if (dst_acc_q) begin
					acc_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W] <= sum_lo;
				end else begin
					xw_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W] <= sum_lo;
				end
				tmp_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W] <= diff_w[WORD_W-1:0];
				carry_q  <= sum_w[WORD_W];
				borrow_q <= diff_w[WORD_W];
				if (wi_last_len) begin
					sel_q <= sum_w[WORD_W] | ~diff_w[WORD_W];
					wi_q  <= '0;
				end else begin
					wi_q <= wi_q + WI_W'(1);
				end
			end
			ST_FIX: begin
				// take the reduced sum when it did not go negative
				if (sel_q) begin
					if (dst_acc_q) begin
						acc_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W] <= tmp_word;
					end else begin
						xw_q[{wi_q, {WORD_LSB{1'b0}}} +: WORD_W] <= tmp_word;
					end
					wi_q <= wi_q + WI_W'(1);
				end
				if (!sel_q || wi_last_len) begin
					if (dst_acc_q) begin
						yv_q[0] <= 1'b0;
					end else begin
						yv_q <= yv_q >> 1;
					end
				end
			end
			ST_MEND: begin
				case (phase_q)
					PH_R: begin
						rv_q    <= acc_q;
						ev_q[0] <= 1'b0;
					end
					PH_B: begin
						bv_q <= acc_q;
						ev_q <= ev_q >> 1;
					end
					default: begin
						rv_q <= acc_q;
						sq_q <= sq_q + S_W'(1);
					end
				endcase
			end
			ST_TEST: begin
				sq_q <= S_W'(1);
			end
			ST_SQR: begin
				res_prime_q <= 1'b0;
				res_bad_q   <= 1'b0;
				phase_q     <= PH_SQ;
				acc_q       <= '0;
				xw_q        <= rv_q;
				yv_q        <= rv_q;
			end
			ST_SQCHK: begin
				res_prime_q <= 1'b0;
				res_bad_q   <= 1'b0;
			end
			ST_DONE: begin
				if (!out_valid_q) begin
					out_prime_q <= res_prime_q;
					out_bad_q   <= res_bad_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/mrpt_checker.sv
// port-level checks for the primality test block, bound to the top level
// depends on miller_rabin_primality_test_defines.svh and mrpt_pkg
`include "miller_rabin_primality_test_defines.svh"

module mrpt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [mrpt_pkg::WORD_W-1:0]       s_axis_tdata,
	input logic                              s_axis_tlast,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [mrpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input logic                              m_axis_tuser,
	input logic                              cfg_we,
	input logic [mrpt_pkg::ROUNDS_W-1:0]     cfg_wdata
);
	import mrpt_pkg::*;

	logic in_last_acc;
	logic out_stall;

	assign in_last_acc = s_axis_tvalid & s_axis_tready & s_axis_tlast;
	assign out_stall   = m_axis_tvalid & ~m_axis_tready;

	// a finished word stays offered until taken
	`MRPT_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid)
	// the last word of a candidate starts the test, intake stops
	`MRPT_ASSERT_NEXT(a_last_stops_intake, in_last_acc, !s_axis_tready)
	// a candidate of one never reads prime
	`MRPT_ASSERT_IMPL(a_bad_not_prime, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[0])
	// pad bits of the result word stay clear
	`MRPT_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:1] == '0)

endmodule

bind miller_rabin_primality_test mrpt_checker u_mrpt_checker (.*);
